@@ design/c_syntax_highlight_lexer_defines.svh @@
// Assertion macros shared by the checker files.
`ifndef C_SYNTAX_HIGHLIGHT_LEXER_DEFINES_SVH
`define C_SYNTAX_HIGHLIGHT_LEXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chl assertion failed");

// Next-cycle implication, disabled during reset.
`define CHL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chl assertion failed");

`endif

@@ design/chl_pkg.sv @@
// Types, constants and helper functions of the C syntax highlight lexer.
package chl_pkg;

   localparam int KwTable = 23;
   localparam int KwCount = 23;
   localparam int KwPlain = 15;
   localparam int PeekN   = 9;

   localparam logic [2:0] ClsNormal  = 3'd0;
   localparam logic [2:0] ClsComment = 3'd1;
   localparam logic [2:0] ClsBlock   = 3'd2;
   localparam logic [2:0] ClsKeyword = 3'd3;
   localparam logic [2:0] ClsType    = 3'd4;
   localparam logic [2:0] ClsString  = 3'd5;
   localparam logic [2:0] ClsNumber  = 3'd6;

   localparam logic [1:0] RegSyntaxEnable = 2'd0;
   localparam logic [1:0] RegHlNumbers    = 2'd1;
   localparam logic [1:0] RegHlStrings    = 2'd2;

   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChDquote = 8'h22;
   localparam logic [7:0] ChSquote = 8'h27;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;

   // Keyword bytes, first character in the low byte.
   localparam logic [63:0] KwWord [KwTable] = '{
      64'h0000_6863_7469_7773, // switch
      64'h0000_0000_0000_6669, // if
      64'h0000_0065_6C69_6877, // while
      64'h0000_0000_0072_6F66, // for
      64'h0000_006B_6165_7262, // break
      64'h6575_6E69_746E_6F63, // continue
      64'h0000_6E72_7574_6572, // return
      64'h0000_0000_6573_6C65, // else
      64'h0000_7463_7572_7473, // struct
      64'h0000_006E_6F69_6E75, // union
      64'h0066_6564_6570_7974, // typedef
      64'h0000_6369_7461_7473, // static
      64'h0000_0000_6D75_6E65, // enum
      64'h0000_0073_7361_6C63, // class
      64'h0000_0000_6573_6163, // case
      64'h0000_0000_0074_6E69, // int
      64'h0000_0000_676E_6F6C, // long
      64'h0000_656C_6275_6F64, // double
      64'h0000_0074_616F_6C66, // float
      64'h0000_0000_7261_6863, // char
      64'h6465_6E67_6973_6E75, // unsigned
      64'h0000_6465_6E67_6973, // signed
      64'h0000_0000_6469_6F76  // void
   };

   localparam logic [3:0] KwLen [KwTable] = '{
      4'd6, 4'd2, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6,
      4'd4, 4'd5, 4'd4, 4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8, 4'd6, 4'd4
   };

   typedef struct packed {
      logic       syntax_enable;
      logic       highlight_numbers;
      logic       highlight_strings;
   } cfg_type;

   typedef struct packed {
      logic       block_open;
      logic [7:0] quote;
      logic       after_sep;
      logic [2:0] prev_class;
      logic [3:0] run_count;
      logic [2:0] run_class;
      logic       line_comment;
   } lex_state_type;

   localparam lex_state_type LexReset = '{
      block_open: 1'b0, quote: 8'd0, after_sep: 1'b1, prev_class: 3'd0,
      run_count: 4'd0, run_class: 3'd0, line_comment: 1'b0
   };

   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      r = (c == 8'h00) || (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      r = r || c == 8'h2C || c == 8'h2E || c == 8'h28 || c == 8'h29;
      r = r || c == 8'h2B || c == 8'h2D || c == 8'h2F || c == 8'h2A;
      r = r || c == 8'h3D || c == 8'h7E || c == 8'h25 || c == 8'h3C;
      r = r || c == 8'h3E || c == 8'h5B || c == 8'h5D || c == 8'h3B;
      return r;
   endfunction

   function automatic logic [5:0] class_color(input logic [2:0] cls);
      logic [5:0] r;
      case (cls)
         ClsComment, ClsBlock: r = 6'd36;
         ClsKeyword:           r = 6'd33;
         ClsType:              r = 6'd32;
         ClsString:            r = 6'd35;
         ClsNumber:            r = 6'd31;
         default:              r = 6'd37;
      endcase
      return r;
   endfunction

   // Clear the state at a line end, but keep the block comment flag.
   function automatic lex_state_type line_reset(input lex_state_type s);
      lex_state_type r;
      r = LexReset;
      r.block_open = s.block_open;
      return r;
   endfunction

endpackage

@@ design/chl_if.sv @@
// Valid/ready channel interfaces for items and results.
interface chl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       has_char;
   logic       last_in_line;
   logic       file_start;

   modport source (output valid, char_code, has_char, last_in_line, file_start,
                   input ready);
   modport sink (input valid, char_code, has_char, last_in_line, file_start,
                 output ready);
endinterface

interface chl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] hl_class;
   logic [5:0] color_code;
   logic       line_done;

   modport source (output valid, hl_class, color_code, line_done, input ready);
   modport sink (input valid, hl_class, color_code, line_done, output ready);
endinterface

@@ design/chl_classify.sv @@
// Classifies the head character of the lookahead window and computes the next lexer state.
module chl_classify #(
   parameter int WINDOW_DEPTH = 10,
   parameter int FillW = 4
) (
   input  logic [7:0]             win [WINDOW_DEPTH],
   input  logic [FillW-1:0]       fill,
   input  chl_pkg::lex_state_type st,
   input  chl_pkg::cfg_type       cfg,
   output logic [2:0]             cls,
   output chl_pkg::lex_state_type st_next
);
   import chl_pkg::*;

   logic [7:0] pk [PeekN];
   logic       kw_hit;
   logic [3:0] kw_len;
   logic [2:0] kw_cls;
   logic       num_hit;

   for (genvar k = 0; k < PeekN; k++) begin : g_peek
      if (k < WINDOW_DEPTH) begin : g_in
         assign pk[k] = (FillW'(k) < fill) ? win[k] : 8'h00;
      end else begin : g_out
         assign pk[k] = 8'h00;
      end
   end

   // Parallel compare of every keyword against the window; first entry wins.
   always_comb begin
      logic match;
      kw_hit = 1'b0;
      kw_len = 4'd0;
      kw_cls = ClsNormal;
      for (int j = 0; j < KwCount; j++) begin
         match = is_sep(pk[KwLen[j]]);
         for (int k = 0; k < 8; k++) begin
            if (4'(k) < KwLen[j] && pk[k] != KwWord[j][8*k +: 8]) begin
               match = 1'b0;
            end
         end
         if (match && !kw_hit) begin
            kw_hit = 1'b1;
            kw_len = KwLen[j];
            kw_cls = (j < KwPlain) ? ClsKeyword : ClsType;
         end
      end
   end

   assign num_hit = ((pk[0] >= ChZero && pk[0] <= ChNine) &&
                     (st.after_sep || st.prev_class == ClsNumber)) ||
                    (pk[0] == ChDot && st.prev_class == ClsNumber);

   always_comb begin
      st_next = st;
      cls = ClsNormal;
      if (!cfg.syntax_enable) begin
         cls = ClsNormal;
      end else if (st.run_count != 4'd0) begin
         st_next.run_count = st.run_count - 4'd1;
         cls = st.run_class;
      end else if (st.line_comment) begin
         cls = ClsComment;
      end else if (st.quote == 8'd0 && !st.block_open && pk[0] == ChSlash &&
                   pk[1] == ChSlash) begin
         st_next.line_comment = 1'b1;
         cls = ClsComment;
      end else if (st.quote == 8'd0 && st.block_open) begin
         if (pk[0] == ChStar && pk[1] == ChSlash) begin
            st_next.run_count  = 4'd1;
            st_next.run_class  = ClsBlock;
            st_next.block_open = 1'b0;
            st_next.after_sep  = 1'b1;
         end
         cls = ClsBlock;
      end else if (st.quote == 8'd0 && pk[0] == ChSlash && pk[1] == ChStar) begin
         st_next.run_count  = 4'd1;
         st_next.run_class  = ClsBlock;
         st_next.block_open = 1'b1;
         cls = ClsBlock;
      end else if (cfg.highlight_strings && st.quote != 8'd0) begin
         if (pk[0] == ChBslash && fill > FillW'(1)) begin
            st_next.run_count = 4'd1;
            st_next.run_class = ClsString;
         end else begin
            if (pk[0] == st.quote) begin
               st_next.quote = 8'd0;
            end
            st_next.after_sep = 1'b1;
         end
         cls = ClsString;
      end else if (cfg.highlight_strings && (pk[0] == ChDquote || pk[0] == ChSquote)) begin
         st_next.quote = pk[0];
         cls = ClsString;
      end else if (cfg.highlight_numbers && num_hit) begin
         st_next.after_sep = 1'b0;
         cls = ClsNumber;
      end else if (st.after_sep && kw_hit) begin
         st_next.run_count = kw_len - 4'd1;
         st_next.run_class = kw_cls;
         st_next.after_sep = 1'b0;
         cls = kw_cls;
      end else begin
         st_next.after_sep = is_sep(pk[0]);
      end
      st_next.prev_class = cls;
   end

endmodule

@@ design/c_syntax_highlight_lexer.sv @@
// C syntax highlight lexer: one character item in, highlight class results out.
// Characters enter a lookahead window of WINDOW_DEPTH entries; once it is full,
// each new character pushes out one result, so a stream runs at one item per
// cycle while results are taken, with results trailing the input by
// WINDOW_DEPTH characters. An item that ends a line flushes the window one
// result per cycle while results are taken, and no item is taken until the
// flush ends. Keyword matching is combinational over the whole table; the
// result register admits new items while a result waits, until the window fills.
module c_syntax_highlight_lexer #(
   parameter int WINDOW_DEPTH = 10
) (
   input  logic       clock,
   input  logic       reset,
   chl_req_if.sink    req_ch,
   chl_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_idx,
   input  logic [0:0] csr_wdata
);
   import chl_pkg::*;

   localparam int FillW = $clog2(WINDOW_DEPTH + 1);

   logic [7:0]    win_ff [WINDOW_DEPTH];
   logic [7:0]    win_in [WINDOW_DEPTH];
   logic [FillW-1:0] fill_ff, fill_in;
   lex_state_type st_ff, st_in, st_cls;
   cfg_type       cfg_ff;
   logic          flush_ff, flush_in;
   logic          rsp_valid_ff;
   logic [2:0]    rsp_class_ff;
   logic          rsp_done_ff;
   logic [2:0]    cls;
   logic          slot_free, full, emit, accept;

   assign full      = (fill_ff == FillW'(WINDOW_DEPTH));
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = (flush_ff || full) && fill_ff != '0 && slot_free;
   assign req_ch.ready = !flush_ff && (!full || slot_free);
   assign accept    = req_ch.valid && req_ch.ready;

   chl_classify #(.WINDOW_DEPTH(WINDOW_DEPTH), .FillW(FillW)) u_cls (
      .win(win_ff), .fill(fill_ff), .st(st_ff), .cfg(cfg_ff),
      .cls(cls), .st_next(st_cls)
   );

   always_comb begin
      logic [FillW-1:0] f;
      f = fill_ff;
      win_in = win_ff;
      st_in = st_ff;
      flush_in = flush_ff;
      // Retire the head first, then apply the new item.
      if (emit) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         f = fill_ff - FillW'(1);
         st_in = st_cls;
         if (flush_ff && fill_ff == FillW'(1)) begin
            flush_in = 1'b0;
            st_in = line_reset(st_cls);
         end
      end
      if (accept) begin
         if (req_ch.file_start) begin
            f = '0;
            st_in = LexReset;
         end
         if (req_ch.has_char && f != FillW'(WINDOW_DEPTH)) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               if (FillW'(i) == f) begin
                  win_in[i] = req_ch.char_code;
               end
            end
            f = f + FillW'(1);
         end
         if (req_ch.last_in_line) begin
            if (f == '0) begin
               st_in = line_reset(st_in);
            end else begin
               flush_in = 1'b1;
            end
         end
      end
      fill_in = f;
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (emit) begin
         rsp_class_ff <= cls;
         rsp_done_ff  <= flush_ff && fill_ff == FillW'(1);
      end
      if (reset) begin
         fill_ff      <= '0;
         st_ff        <= LexReset;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{syntax_enable: 1'b0, highlight_numbers: 1'b1,
                           highlight_strings: 1'b1};
      end else begin
         fill_ff  <= fill_in;
         st_ff    <= st_in;
         flush_ff <= flush_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_idx)
               RegSyntaxEnable: cfg_ff.syntax_enable     <= csr_wdata[0];
               RegHlNumbers:    cfg_ff.highlight_numbers <= csr_wdata[0];
               RegHlStrings:    cfg_ff.highlight_strings <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hl_class   = rsp_class_ff;
   assign rsp_ch.color_code = class_color(rsp_class_ff);
   assign rsp_ch.line_done  = rsp_done_ff;

endmodule

@@ design/chl_checker.sv @@
// Port-level assertions for the lexer, bound to the top level.
`include "c_syntax_highlight_lexer_defines.svh"

module chl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_has_char,
   input logic       req_last_in_line,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_hl_class,
   input logic [5:0] rsp_color_code
);
   import chl_pkg::*;

   // A waiting result holds its class.
   `CHL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hl_class))

   // Color follows class.
   `CHL_ASSERT_NOW(a_color, rsp_valid, rsp_color_code == class_color(rsp_hl_class))

   // Class code stays within the defined range.
   `CHL_ASSERT_NOW(a_class_range, rsp_valid, rsp_hl_class <= ClsNumber)

   // A line ending with a character starts a flush that blocks the input.
   `CHL_ASSERT_NEXT(a_flush_stall,
      req_valid && req_ready && req_has_char && req_last_in_line, !req_ready)

endmodule

bind c_syntax_highlight_lexer chl_checker u_chl_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .req_has_char(req_ch.has_char),
   .req_last_in_line(req_ch.last_in_line),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_hl_class(rsp_ch.hl_class),
   .rsp_color_code(rsp_ch.color_code)
);

@@ tb/chl_tb_if.sv @@
// Testbench package with the item and result structs used by the stimulus and scoreboard.
`timescale 1ns / 100ps
package chl_tb_pkg;
   import chl_pkg::*;

   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       last_in_line;
      logic       file_start;
   } req_item_type;

   typedef struct packed {
      logic [2:0] hl_class;
      logic [5:0] color_code;
      logic       line_done;
   } hl_result_type;
endpackage

@@ tb/testbench.sv @@
// Testbench for the C syntax highlight lexer: directed lines, random C-like lines, checks.
`timescale 1ns / 100ps
module testbench;
   import chl_pkg::*;
   import chl_tb_pkg::*;

   localparam int Depth = 10;
   localparam int CycleLimit = 400000;

   // Scoreboard: holds the lexer state and the queue of expected highlight results.
   class hl_scoreboard;
      logic [7:0] win [Depth];
      int         fill;
      logic       blk, lcom, asep;
      logic [7:0] quote;
      logic [2:0] prev, rcls;
      int         rcnt;
      logic       en, nums, strs;
      hl_result_type pending[$];
      int         errors, checked;

      function void clear_line();
         quote = 0; asep = 1; prev = ClsNormal; rcnt = 0; rcls = ClsNormal; lcom = 0;
      endfunction

      function void init();
         en = 0; nums = 1; strs = 1; fill = 0; blk = 0; clear_line();
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic v);
         case (idx)
            RegSyntaxEnable: en = v;
            RegHlNumbers:    nums = v;
            RegHlStrings:    strs = v;
            default: ;
         endcase
      endfunction

      function logic [7:0] at(int k);
         return (k < fill) ? win[k] : 8'h00;
      endfunction

      function logic [2:0] class_head();
         logic [7:0] c, n1;
         logic [63:0] w;
         int len;
         logic hit;
         c = at(0); n1 = at(1);
         if (!en) return ClsNormal;
         if (rcnt != 0) begin
            rcnt--;
            return rcls;
         end
         if (lcom) return ClsComment;
         if (quote == 0 && !blk && c == ChSlash && n1 == ChSlash) begin
            lcom = 1;
            return ClsComment;
         end
         if (quote == 0) begin
            if (blk) begin
               if (c == ChStar && n1 == ChSlash) begin
                  rcnt = 1; rcls = ClsBlock; blk = 0; asep = 1;
               end
               return ClsBlock;
            end
            if (c == ChSlash && n1 == ChStar) begin
               rcnt = 1; rcls = ClsBlock; blk = 1;
               return ClsBlock;
            end
         end
         if (strs) begin
            if (quote != 0) begin
               if (c == ChBslash && fill > 1) begin
                  rcnt = 1; rcls = ClsString;
                  return ClsString;
               end
               if (c == quote) quote = 0;
               asep = 1;
               return ClsString;
            end
            if (c == ChDquote || c == ChSquote) begin
               quote = c;
               return ClsString;
            end
         end
         if (nums) begin
            if ((c >= ChZero && c <= ChNine && (asep || prev == ClsNumber)) ||
                (c == ChDot && prev == ClsNumber)) begin
               asep = 0;
               return ClsNumber;
            end
         end
         if (asep) begin
            for (int j = 0; j < KwCount; j++) begin
               w = KwWord[j];
               len = KwLen[j];
               hit = 1;
               for (int k = 0; k < len; k++)
                  if (at(k) != w[8*k +: 8]) hit = 0;
               if (hit && is_sep(at(len))) begin
                  rcnt = len - 1;
                  rcls = (j < KwPlain) ? ClsKeyword : ClsType;
                  asep = 0;
                  return rcls;
               end
            end
         end
         asep = is_sep(c);
         return ClsNormal;
      endfunction

      function void pop_head(logic done);
         hl_result_type r;
         r.hl_class = class_head();
         prev = r.hl_class;
         r.color_code = class_color(r.hl_class);
         r.line_done = done;
         pending.push_back(r);
         for (int i = 1; i < fill; i++) win[i-1] = win[i];
         if (fill != 0) fill--;
      endfunction

      function void note_item(req_item_type it);
         if (it.file_start) begin
            fill = 0; blk = 0; clear_line();
         end
         if (it.has_char && fill < Depth) begin
            win[fill] = it.char_code;
            fill++;
         end
         if (it.last_in_line) begin
            while (fill != 0) pop_head(fill == 1);
            clear_line();
         end else if (fill >= Depth) begin
            pop_head(0);
         end
      endfunction

      function void check_result(hl_result_type got);
         hl_result_type exp;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp class %0d color %0d done %0d, got %0d %0d %0d",
                        exp.hl_class, exp.color_code, exp.line_done,
                        got.hl_class, got.color_code, got.line_done);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_we = 0;
   logic [1:0] csr_idx = 0;
   logic [0:0] csr_wdata = 0;
   int         cycles = 0;
   int         sent = 0;
   bit         idle_on = 1;
   bit         hold_rsp = 0;
   hl_scoreboard sb;

   chl_req_if req_ch ();
   chl_rsp_if rsp_ch ();

   c_syntax_highlight_lexer #(.WINDOW_DEPTH(Depth)) u_dut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we, .csr_idx, .csr_wdata
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0; req_ch.char_code = 0; req_ch.has_char = 0;
      req_ch.last_in_line = 0; req_ch.file_start = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout");
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stall bursts, plus a forced hold-off when asked.
   initial begin : rsp_side
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            rsp_ch.ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result('{rsp_ch.hl_class, rsp_ch.color_code, rsp_ch.line_done});

   task automatic send_item(req_item_type it);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.char_code <= it.char_code;
      req_ch.has_char <= it.has_char;
      req_ch.last_in_line <= it.last_in_line;
      req_ch.file_start <= it.file_start;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
      sent++;
   endtask

   task automatic send_line(string s, bit fs);
      req_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it = '{s[i], 1'b1, i == s.len() - 1, fs && i == 0};
         send_item(it);
      end
      if (s.len() == 0) send_item('{8'h00, 1'b0, 1'b1, fs});
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_regs(logic e, logic n, logic s);
      logic v [3];
      v = '{e, n, s};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1;
         csr_idx <= i[1:0];
         csr_wdata <= (i < 3) ? v[i] : 1'b1;
         @(posedge clock);
         sb.write_reg(i[1:0], (i < 3) ? v[i] : 1'b1);
      end
      csr_we <= 0;
   endtask

   string words [] = '{"if", "while", "continue", "unsigned", "int", "void", "char",
                       "return", "typedef", "x1", "foo", "12.5", "3", "\"a\\\"b\"",
                       "'c'", "/*", "*/", "//", "(", ")", ";", " ", "+", "*", "\\",
                       "signedx", "0x7f", "..", "=", "\t"};

   function automatic string rand_line();
      string s;
      int n;
      s = "";
      n = $urandom_range(0, 7);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
         else s = {s, words[$urandom_range(0, words.size() - 1)]};
         if ($urandom_range(0, 1)) s = {s, " "};
      end
      return s;
   endfunction

   initial begin : stimulus
      req_item_type it;
      sb = new();
      sb.init();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      set_regs(1, 1, 1);
      // directed: keywords, comments, strings, escapes, numbers, empty line
      send_line("if(x)continue;", 1);
      send_line("unsigned int a=12.5; /* open", 0);
      send_line("still */ \"s\\\"q\" 'c\\", 0);
      send_line("", 0);
      send_item('{8'hFF, 1'b0, 1'b0, 1'b0});
      send_line({"a", 8'h00, "void", 8'h80, "//x"}, 0);
      send_line("/* dropped", 0);
      send_line("int", 1);
      drain();
      set_regs(0, 0, 0);
      send_line("while 42 \"x\"", 0);
      drain();
      set_regs(1, 0, 0);
      send_line("\"ab // c\" 7.1 for", 0);
      drain();
      // long hold-off on the result side while items keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         send_line("switch (a) { case 1: break; default: return 0; } // end", 0);
      join
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         set_regs(ph != 3, ph[0], ph != 1);
         while (sent < 80 * (ph + 1) + 40) begin
            if ($urandom_range(0, 9) == 0) begin
               it = '{8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)};
               send_item(it);
            end else begin
               send_line(rand_line(), $urandom_range(0, 15) == 0);
            end
         end
         // end the line so the window is empty before the registers change
         send_item('{8'h00, 1'b0, 1'b1, 1'b0});
         drain();
      end
      set_regs(1, 1, 1);
      idle_on = 0;
      while (sent < 440) send_line(rand_line(), 0);
      drain();
      $display("Covered %0d items and %0d results over keyword, comment, string",
               sent, sb.checked);
      $display("and number lexing with several register settings and stalls.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("errors: %0d, left over: %0d", sb.errors, sb.pending.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+design
design/chl_pkg.sv
design/chl_if.sv
design/chl_classify.sv
design/c_syntax_highlight_lexer.sv
design/chl_checker.sv
tb/chl_tb_if.sv
tb/testbench.sv
